// ===== rtl/pcpfa_pkg.sv =====
`default_nettype none
package pcpfa_pkg;

    // Default sizing
    localparam int DEF_NUM_CPUS   = 8;
    localparam int DEF_NUM_PAGES  = 32768;
    localparam int DEF_PAGE_SHIFT = 12;

    // Field widths fixed by the interface
    localparam int ADDR_W   = 32;
    localparam int CPU_IN_W = 3;
    localparam int STATUS_W = 2;

    // Configuration register reset values
    localparam logic [ADDR_W-1:0] REGION_BASE_RST = 32'h8000_0000;
    localparam logic [ADDR_W-1:0] REGION_TOP_RST  = 32'h8800_0000;

    // Register index, decoded from paddr[2]
    localparam logic REG_REGION_BASE = 1'b0;
    localparam logic REG_REGION_TOP  = 1'b1;

    // Request kinds
    localparam logic KIND_FREE  = 1'b0;
    localparam logic KIND_ALLOC = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_FCHK,
        S_PUSH,
        S_FIND,
        S_HEAD,
        S_POP
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/pcpfa_ram.sv =====
`default_nettype none
module pcpfa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire                                  i_clk,
    input  wire                                  i_we,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire [WIDTH-1:0]                      i_wdata,
    input  wire                                  i_re,
    input  wire [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, hold data between reads
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/pcpfa_addr.sv =====
`default_nettype none
module pcpfa_addr
    import pcpfa_pkg::*;
#(
    parameter int NUM_PAGES  = DEF_NUM_PAGES,
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_sel,
    input  wire [ADDR_W-1:0]             i_cfg_wdata,
    output logic [ADDR_W-1:0]            o_cfg_rdata,
    input  wire [ADDR_W-1:0]             i_page_address,
    output logic                         o_bad,
    output logic [$clog2(NUM_PAGES)-1:0] o_idx,
    input  wire [$clog2(NUM_PAGES)-1:0]  i_grant_idx,
    output logic [ADDR_W-1:0]            o_granted
);

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int BW    = ADDR_W + 1;
    localparam int GW    = ADDR_W + 5;
    localparam logic [BW-1:0] PG_MASK = BW'((64'd1 << PAGE_SHIFT) - 64'd1);

    logic [ADDR_W-1:0] r_region_base;
    logic [ADDR_W-1:0] r_region_top;
    logic [BW-1:0]     r_abase;
    logic [BW-1:0]     n_abase;
    logic [BW-1:0]     diff;
    logic [BW-1:0]     page_num;
    logic [GW-1:0]     grant_sum;

    // Round the written base up to a page boundary
    assign n_abase = ({1'b0, i_cfg_wdata} + PG_MASK) & ~PG_MASK;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_region_base <= REGION_BASE_RST;
            r_region_top  <= REGION_TOP_RST;
            r_abase       <= {1'b0, REGION_BASE_RST};
        end else if (i_cfg_we) begin
            if (i_cfg_sel == REG_REGION_BASE) begin
                r_region_base <= i_cfg_wdata;
                r_abase       <= n_abase;
            end else begin
                r_region_top <= i_cfg_wdata;
            end
        end
    end

    assign o_cfg_rdata = (i_cfg_sel == REG_REGION_BASE) ? r_region_base : r_region_top;

    // Check a freed address and derive its page index
    assign diff     = {1'b0, i_page_address} - r_abase;
    assign page_num = diff >> PAGE_SHIFT;
    assign o_idx    = page_num[IDX_W-1:0];
    assign o_bad    = ((i_page_address & PG_MASK[ADDR_W-1:0]) != '0)
                   || (i_page_address < r_region_base)
                   || (i_page_address >= r_region_top)
                   || ({1'b0, i_page_address} < r_abase)
                   || (page_num >= BW'(NUM_PAGES));

    // Rebuild a byte address from a page index and the current base
    assign grant_sum = GW'(r_abase) + (GW'(i_grant_idx) << PAGE_SHIFT);
    assign o_granted = grant_sum[ADDR_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/per_cpu_page_free_list_allocator_unit.sv =====
`default_nettype none
// Per-CPU page free-list allocator with stealing.
// Request channel (i_valid/o_ready): i_kind selects free (0) or allocate (1),
// i_cpu names the caller, i_page_address is the page freed. Result channel
// (o_valid/i_ready): one transfer per request with o_granted_address and
// o_status (0 ok, 1 out of memory, 2 bad free address).
// Requests are handled one at a time by a sequencer around two RAMs: the
// list head RAM (one entry per CPU) and the link RAM (one entry per page).
// A good free checks the address and reads the head, then writes the link and
// head and registers its result. An allocate searches the valid bits and
// reads the head, reads the link, then writes back and registers its result.
// A rejected free or an out-of-memory request registers it in its first step.
// The next request transfers in the cycle after the result is registered.
// The result sits in an output register: a stalled receiver does not block
// the next request, but a request waits in its last step while the previous
// result is still held. Reset empties all lists at once (per-CPU valid
// flops) and restores region_base/region_top; the link RAM needs no clearing.
// Config: APB, region_base at 0x0, region_top at 0x4, pready always high.
module per_cpu_page_free_list_allocator_unit
    import pcpfa_pkg::*;
#(
    parameter int NUM_CPUS   = DEF_NUM_CPUS,
    parameter int NUM_PAGES  = DEF_NUM_PAGES,
    parameter int PAGE_SHIFT = DEF_PAGE_SHIFT
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire                 i_kind,
    input  wire [CPU_IN_W-1:0]  i_cpu,
    input  wire [ADDR_W-1:0]    i_page_address,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [ADDR_W-1:0]   o_granted_address,
    output logic [STATUS_W-1:0] o_status,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire [2:0]           paddr,
    input  wire [ADDR_W-1:0]    pwdata,
    output logic [ADDR_W-1:0]   prdata,
    output logic                pready
);

    localparam int IDX_W  = $clog2(NUM_PAGES);
    localparam int CPU_W  = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int LINK_W = IDX_W + 1;
    localparam logic [6:0] NCPU7 = 7'(NUM_CPUS);

    t_state               r_state, n_state;
    logic [CPU_W-1:0]     r_cpu;
    logic [ADDR_W-1:0]    r_addr;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [CPU_W-1:0]     r_src, n_src;
    logic [NUM_CPUS-1:0]  r_hvalid;
    logic                 r_out_valid;
    logic [ADDR_W-1:0]    r_grant;
    logic [STATUS_W-1:0]  r_status;

    logic                 accept;
    logic [CPU_W-1:0]     cpu_mod;
    logic                 out_free;
    logic                 out_load;
    logic [ADDR_W-1:0]    out_grant;
    logic [STATUS_W-1:0]  out_status;
    logic                 set_push;
    logic                 set_pop;

    logic                 find_any;
    logic [CPU_W-1:0]     find_src;

    logic                 head_we, head_re;
    logic [CPU_W-1:0]     head_waddr, head_raddr;
    logic [IDX_W-1:0]     head_wdata, head_rdata;
    logic                 link_we, link_re;
    logic [IDX_W-1:0]     link_waddr, link_raddr;
    logic [LINK_W-1:0]    link_wdata, link_rdata;

    logic                 chk_bad;
    logic [IDX_W-1:0]     chk_idx;
    logic [ADDR_W-1:0]    granted;
    logic                 cfg_we;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    pcpfa_addr #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_addr (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_sel      (paddr[2]),
        .i_cfg_wdata    (pwdata),
        .o_cfg_rdata    (prdata),
        .i_page_address (r_addr),
        .o_bad          (chk_bad),
        .o_idx          (chk_idx),
        .i_grant_idx    (r_idx),
        .o_granted      (granted)
    );

    // List heads, one entry per CPU
    pcpfa_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_CPUS)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_re    (head_re),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    // Next links, one entry per page: {has_next, next_index}
    pcpfa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_PAGES)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    // Fold the caller number into the CPU range
    always_comb begin
        logic [6:0] t;
        t = 7'(i_cpu);
        for (int i = 0; i < 8; i++) begin
            if (t >= NCPU7) begin
                t = t - NCPU7;
            end
        end
        cpu_mod = CPU_W'(t);
    end

    // Circular search for a non-empty list, own list first, then the next CPUs
    always_comb begin
        logic [CPU_W:0] cand;
        find_src = r_cpu;
        find_any = |r_hvalid;
        for (int k = NUM_CPUS - 1; k >= 1; k--) begin
            cand = {1'b0, r_cpu} + (CPU_W + 1)'(k);
            if (cand >= (CPU_W + 1)'(NUM_CPUS)) begin
                cand = cand - (CPU_W + 1)'(NUM_CPUS);
            end
            if (r_hvalid[cand[CPU_W-1:0]]) begin
                find_src = cand[CPU_W-1:0];
            end
        end
        if (r_hvalid[r_cpu]) begin
            find_src = r_cpu;
        end
    end

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid & o_ready;
    assign out_free = ~r_out_valid | i_ready;

    // Sequencer: next state, RAM controls, result load
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_src      = r_src;
        head_we    = 1'b0;
        head_waddr = r_cpu;
        head_wdata = r_idx;
        head_re    = 1'b0;
        head_raddr = r_cpu;
        link_we    = 1'b0;
        link_waddr = r_idx;
        link_wdata = {r_hvalid[r_cpu], head_rdata};
        link_re    = 1'b0;
        link_raddr = head_rdata;
        out_load   = 1'b0;
        out_grant  = '0;
        out_status = ST_OK;
        set_push   = 1'b0;
        set_pop    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = (i_kind == KIND_ALLOC) ? S_FIND : S_FCHK;
                end
            end
            S_FCHK: begin
                if (chk_bad) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_status = ST_BADFREE;
                        n_state    = S_IDLE;
                    end
                end else begin
                    head_re = 1'b1;
                    n_idx   = chk_idx;
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    link_we  = 1'b1;
                    head_we  = 1'b1;
                    set_push = 1'b1;
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_FIND: begin
                if (!find_any) begin
                    if (out_free) begin
                        out_load   = 1'b1;
                        out_status = ST_OOM;
                        n_state    = S_IDLE;
                    end
                end else begin
                    head_re    = 1'b1;
                    head_raddr = find_src;
                    n_src      = find_src;
                    n_state    = S_HEAD;
                end
            end
            S_HEAD: begin
                link_re = 1'b1;
                n_idx   = head_rdata;
                n_state = S_POP;
            end
            S_POP: begin
                if (out_free) begin
                    head_we    = 1'b1;
                    head_waddr = r_src;
                    head_wdata = link_rdata[IDX_W-1:0];
                    set_pop    = 1'b1;
                    out_load   = 1'b1;
                    out_grant  = granted;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_hvalid    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (set_push) begin
                r_hvalid[r_cpu] <= 1'b1;
            end else if (set_pop) begin
                r_hvalid[r_src] <= link_rdata[IDX_W];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request and result payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cpu  <= cpu_mod;
            r_addr <= i_page_address;
        end
        r_idx <= n_idx;
        r_src <= n_src;
        if (out_load) begin
            r_grant  <= out_grant;
            r_status <= out_status;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_granted_address = r_grant;
    assign o_status          = r_status;

endmodule
`default_nettype wire
